/* rtl/core/sorted_table_block_entry_parser_unit_assert.svh */
// Assertion macros for the sorted-table block entry parser.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef SORTED_TABLE_BLOCK_ENTRY_PARSER_UNIT_ASSERT_SVH
`define SORTED_TABLE_BLOCK_ENTRY_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Expression holds at every clock edge outside reset.
`define STBEP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define STBEP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STBEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STBEP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define STBEP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define STBEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/stbep_pkg.sv */
// Shared types and codes of the sorted-table block entry parser.
// No dependencies; used by the interfaces, the varint stage and the top level.
package stbep_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int OUT_LEN_W = 9;   // width of shared_len / key_len on the result
  localparam int KIND_W    = 2;
  localparam int ERR_W     = 2;
  localparam int VCNT_W    = 3;   // varint byte counter

  localparam logic [BYTE_W-1:0] VARINT_DATA_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0] VARINT_CONT_MASK = 8'h80;

  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

  localparam logic [ERR_W-1:0] ERR_VARINT_LONG = 2'd0;
  localparam logic [ERR_W-1:0] ERR_KEY_LONG    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED   = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] acc;       // accumulator with this byte merged in
    logic [VCNT_W-1:0] count;     // byte count including this byte
    logic              more;      // continuation bit set
    logic              too_long;  // this byte is the last allowed byte
  } varint_step_t;

endpackage

/* rtl/core/stbep_in_if.sv */
// Input channel of the entry parser: one block byte per transaction.
// Depends on stbep_pkg.
interface stbep_in_if;
  import stbep_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

/* rtl/core/stbep_out_if.sv */
// Result channel of the entry parser: one header, key byte, value byte or error.
// Depends on stbep_pkg.
interface stbep_out_if;
  import stbep_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [BYTE_W-1:0]    byte_out;
  logic [WORD_W-1:0]    position;
  logic [OUT_LEN_W-1:0] shared_len;
  logic [OUT_LEN_W-1:0] key_len;
  logic [WORD_W-1:0]    value_len;
  logic                 zero_filled;
  logic                 entry_end;
  logic                 block_end;
  logic [ERR_W-1:0]     error_code;

  modport source (output valid, output kind, output byte_out, output position,
                  output shared_len, output key_len, output value_len,
                  output zero_filled, output entry_end, output block_end,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input byte_out, input position,
                  input shared_len, input key_len, input value_len,
                  input zero_filled, input entry_end, input block_end,
                  input error_code, output ready);
endinterface

/* rtl/core/sorted_table_block_entry_parser_unit.sv */
// Sorted-table block entry parser: bytes in, headers / key bytes / value bytes out.
// Path: an accepted byte enters the input register, then one pass of phase logic
// loads its result into the result register.
// Throughput: one byte per cycle while the result register is free or drains.
// Bytes that yield no result (varint bytes, skipped bytes) pass at the same rate.
// Reset: synchronous, active low; clears all parser state, no clearing pass.
`include "sorted_table_block_entry_parser_unit_assert.svh"

module sorted_table_block_entry_parser_unit #(
  parameter int KEY_MAX      = 256,
  parameter int VARINT_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  stbep_in_if.sink    in_if,
  stbep_out_if.source out_if
);
  import stbep_pkg::*;

  localparam int KLEN_W = $clog2(KEY_MAX + 1);

  typedef enum logic [2:0] {
    PH_SHARED = 3'd0,
    PH_NEWKEY = 3'd1,
    PH_VALLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  // Input register
  logic              s0_valid_r;
  logic [BYTE_W-1:0] s0_byte_r;
  logic              s0_end_r;

  // Parser state
  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] varint_acc_r, varint_acc_nxt;
  logic [VCNT_W-1:0] varint_count_r, varint_count_nxt;
  logic [KLEN_W-1:0] shared_count_r, shared_count_nxt;
  logic [KLEN_W-1:0] new_key_count_r, new_key_count_nxt;
  logic [WORD_W-1:0] value_count_r, value_count_nxt;
  logic [WORD_W-1:0] byte_index_r, byte_index_nxt;
  logic [KLEN_W-1:0] prev_key_len_r, prev_key_len_nxt;
  logic              skip_to_end_r, skip_to_end_nxt;

  // Result register
  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [WORD_W-1:0]    out_position_r;
  logic [OUT_LEN_W-1:0] out_shared_len_r;
  logic [OUT_LEN_W-1:0] out_key_len_r;
  logic [WORD_W-1:0]    out_value_len_r;
  logic                 out_zero_filled_r;
  logic                 out_entry_end_r;
  logic                 out_block_end_r;
  logic [ERR_W-1:0]     out_error_code_r;

  // Result of the current pass
  logic                 res_valid;
  logic [KIND_W-1:0]    res_kind;
  logic [BYTE_W-1:0]    res_byte;
  logic [WORD_W-1:0]    res_position;
  logic [OUT_LEN_W-1:0] res_shared_len;
  logic [OUT_LEN_W-1:0] res_key_len;
  logic [WORD_W-1:0]    res_value_len;
  logic                 res_zero_filled;
  logic                 res_entry_end;
  logic [ERR_W-1:0]     res_error_code;

  logic              advance;
  logic              s1_fire;
  varint_step_t      vstep;
  logic              fail_req;
  logic [ERR_W-1:0]  fail_code;
  logic              restart;
  logic              entry_done;
  logic [KLEN_W-1:0] key_sum;
  logic [WORD_W-1:0] idx_inc;
  logic [WORD_W-1:0] key_room;
  logic              key_last;

  // The processing stage moves whenever the result register is free or drains
  // this cycle; the input register refills behind it.
  assign advance     = !out_valid_r || out_if.ready;
  assign s1_fire     = s0_valid_r && advance;
  assign in_if.ready = !s0_valid_r || advance;

  stbep_varint #(
    .VARINT_BYTES (VARINT_BYTES)
  ) u_varint (
    .acc       (varint_acc_r),
    .count     (varint_count_r),
    .data_byte (s0_byte_r),
    .step      (vstep)
  );

  assign key_sum  = shared_count_r + new_key_count_r;
  assign idx_inc  = byte_index_r + WORD_W'(1);
  assign key_room = WORD_W'(KEY_MAX) - WORD_W'(shared_count_r);
  assign key_last = idx_inc >= WORD_W'(new_key_count_r);

  always_comb begin
    phase_nxt         = phase_r;
    varint_acc_nxt    = varint_acc_r;
    varint_count_nxt  = varint_count_r;
    shared_count_nxt  = shared_count_r;
    new_key_count_nxt = new_key_count_r;
    value_count_nxt   = value_count_r;
    byte_index_nxt    = byte_index_r;
    prev_key_len_nxt  = prev_key_len_r;
    skip_to_end_nxt   = skip_to_end_r;

    res_valid       = 1'b0;
    res_kind        = KIND_HEADER;
    res_byte        = '0;
    res_position    = '0;
    res_shared_len  = '0;
    res_key_len     = '0;
    res_value_len   = '0;
    res_zero_filled = 1'b0;
    res_entry_end   = 1'b0;
    res_error_code  = ERR_VARINT_LONG;

    fail_req   = 1'b0;
    fail_code  = ERR_VARINT_LONG;
    restart    = 1'b0;
    entry_done = 1'b0;

    if (skip_to_end_r) begin
      // Swallow bytes after an error up to the region end
      restart = s0_end_r;
    end else begin
      case (phase_r)
        PH_SHARED, PH_NEWKEY, PH_VALLEN: begin
          if (vstep.more) begin
            varint_acc_nxt   = vstep.acc;
            varint_count_nxt = vstep.count;
            if (vstep.too_long) begin
              fail_req  = 1'b1;
              fail_code = ERR_VARINT_LONG;
            end else if (s0_end_r) begin
              fail_req  = 1'b1;
              fail_code = ERR_TRUNCATED;
            end
          end else begin
            varint_acc_nxt   = '0;
            varint_count_nxt = '0;
            if (phase_r == PH_SHARED) begin
              shared_count_nxt = KLEN_W'(vstep.acc);
              if (vstep.acc > WORD_W'(KEY_MAX)) begin
                fail_req  = 1'b1;
                fail_code = ERR_KEY_LONG;
              end else if (s0_end_r) begin
                fail_req  = 1'b1;
                fail_code = ERR_TRUNCATED;
              end else begin
                phase_nxt = PH_NEWKEY;
              end
            end else if (phase_r == PH_NEWKEY) begin
              new_key_count_nxt = KLEN_W'(vstep.acc);
              if (vstep.acc > key_room) begin
                fail_req  = 1'b1;
                fail_code = ERR_KEY_LONG;
              end else if (s0_end_r) begin
                fail_req  = 1'b1;
                fail_code = ERR_TRUNCATED;
              end else begin
                phase_nxt = PH_VALLEN;
              end
            end else begin
              // Value length complete: emit the entry header, or a truncation error
              value_count_nxt = vstep.acc;
              entry_done      = (new_key_count_r == '0) && (vstep.acc == '0);
              if (s0_end_r && !entry_done) begin
                fail_req  = 1'b1;
                fail_code = ERR_TRUNCATED;
              end else begin
                res_valid       = 1'b1;
                res_kind        = KIND_HEADER;
                res_shared_len  = OUT_LEN_W'(shared_count_r);
                res_key_len     = OUT_LEN_W'(key_sum);
                res_value_len   = vstep.acc;
                res_zero_filled = shared_count_r > prev_key_len_r;
                res_entry_end   = entry_done;
                byte_index_nxt  = '0;
                if (!entry_done) begin
                  phase_nxt = (new_key_count_r != '0) ? PH_KEY : PH_VALUE;
                end
              end
            end
          end
        end
        PH_KEY: begin
          entry_done = key_last && (value_count_r == '0);
          if (s0_end_r && !entry_done) begin
            fail_req  = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            res_valid      = 1'b1;
            res_kind       = KIND_KEY;
            res_byte       = s0_byte_r;
            res_position   = WORD_W'(shared_count_r) + byte_index_r;
            res_entry_end  = entry_done;
            byte_index_nxt = idx_inc;
            if (!entry_done && key_last) begin
              phase_nxt      = PH_VALUE;
              byte_index_nxt = '0;
            end
          end
        end
        PH_VALUE: begin
          entry_done = idx_inc >= value_count_r;
          if (s0_end_r && !entry_done) begin
            fail_req  = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            res_valid      = 1'b1;
            res_kind       = KIND_VALUE;
            res_byte       = s0_byte_r;
            res_position   = byte_index_r;
            res_entry_end  = entry_done;
            byte_index_nxt = idx_inc;
          end
        end
        default: begin
          // Unreachable phase code: drop the byte and start over
          restart = 1'b1;
        end
      endcase

      if (fail_req) begin
        res_valid      = 1'b1;
        res_kind       = KIND_ERROR;
        res_error_code = fail_code;
        res_entry_end  = 1'b1;
        if (s0_end_r) begin
          restart = 1'b1;
        end else begin
          skip_to_end_nxt = 1'b1;
        end
      end else if (entry_done) begin
        // Close the entry; the next one shares against this key
        prev_key_len_nxt = key_sum;
        phase_nxt        = PH_SHARED;
        byte_index_nxt   = '0;
        restart          = s0_end_r;
      end
    end

    // Region end or recovery: back to the empty-key start
    if (restart) begin
      phase_nxt         = PH_SHARED;
      varint_acc_nxt    = '0;
      varint_count_nxt  = '0;
      shared_count_nxt  = '0;
      new_key_count_nxt = '0;
      value_count_nxt   = '0;
      byte_index_nxt    = '0;
      prev_key_len_nxt  = '0;
      skip_to_end_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      phase_r         <= PH_SHARED;
      varint_acc_r    <= '0;
      varint_count_r  <= '0;
      shared_count_r  <= '0;
      new_key_count_r <= '0;
      value_count_r   <= '0;
      byte_index_r    <= '0;
      prev_key_len_r  <= '0;
      skip_to_end_r   <= 1'b0;
    end else begin
      // Input register: hold while the processing stage stalls
      if (in_if.ready) begin
        s0_valid_r <= in_if.valid;
      end
      // Parser state: advance once per processed byte
      if (s1_fire) begin
        phase_r         <= phase_nxt;
        varint_acc_r    <= varint_acc_nxt;
        varint_count_r  <= varint_count_nxt;
        shared_count_r  <= shared_count_nxt;
        new_key_count_r <= new_key_count_nxt;
        value_count_r   <= value_count_nxt;
        byte_index_r    <= byte_index_nxt;
        prev_key_len_r  <= prev_key_len_nxt;
        skip_to_end_r   <= skip_to_end_nxt;
      end
      // Result register: drop the old transaction when taken, load a new one
      if (advance) begin
        out_valid_r <= s1_fire && res_valid;
      end
    end

    // Payload registers, no reset
    if (in_if.valid && in_if.ready) begin
      s0_byte_r <= in_if.data_byte;
      s0_end_r  <= in_if.region_end;
    end
    if (s1_fire && res_valid) begin
      out_kind_r        <= res_kind;
      out_byte_r        <= res_byte;
      out_position_r    <= res_position;
      out_shared_len_r  <= res_shared_len;
      out_key_len_r     <= res_key_len;
      out_value_len_r   <= res_value_len;
      out_zero_filled_r <= res_zero_filled;
      out_entry_end_r   <= res_entry_end;
      out_block_end_r   <= s0_end_r;
      out_error_code_r  <= res_error_code;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.byte_out    = out_byte_r;
  assign out_if.position    = out_position_r;
  assign out_if.shared_len  = out_shared_len_r;
  assign out_if.key_len     = out_key_len_r;
  assign out_if.value_len   = out_value_len_r;
  assign out_if.zero_filled = out_zero_filled_r;
  assign out_if.entry_end   = out_entry_end_r;
  assign out_if.block_end   = out_block_end_r;
  assign out_if.error_code  = out_error_code_r;

  // Every error closes its entry
  `STBEP_ASSERT_IMPL(a_error_ends_entry, clk, rst_n, out_valid_r && out_kind_r == KIND_ERROR, out_entry_end_r, "error transaction without entry_end")

  // While swallowing bytes after an error no result is produced
  `STBEP_ASSERT_IMPL(a_skip_silent, clk, rst_n, s1_fire && skip_to_end_r, !res_valid, "result produced while skipping to region end")

  // Any processed region end byte returns the parser to its start state
  `STBEP_ASSERT_NEXT(a_region_end_restart, clk, rst_n, s1_fire && s0_end_r, phase_r == PH_SHARED && prev_key_len_r == '0 && !skip_to_end_r && varint_count_r == '0, "parser state not cleared after region end")

  // A live varint never holds more bytes than allowed
  `STBEP_ASSERT_IMPL(a_varint_bound, clk, rst_n, !skip_to_end_r, varint_count_r < VCNT_W'(VARINT_BYTES), "varint byte count beyond limit")

endmodule

/* rtl/core/stbep_varint.sv */
// Base-128 varint step: merges one byte into the running accumulator.
// Depends on stbep_pkg.
module stbep_varint #(
  parameter int VARINT_BYTES = 5
) (
  input  logic [stbep_pkg::WORD_W-1:0] acc,
  input  logic [stbep_pkg::VCNT_W-1:0] count,
  input  logic [stbep_pkg::BYTE_W-1:0] data_byte,
  output stbep_pkg::varint_step_t      step
);
  import stbep_pkg::*;

  logic [5:0]              shamt;
  logic [2*WORD_W-1:0]     shifted;
  logic [VCNT_W-1:0]       count_inc;
  logic [BYTE_W-1:0]       payload;

  // 7 * count, written as 8 * count - count
  assign shamt     = {count, 3'b000} - {3'b000, count};
  assign payload   = data_byte & VARINT_DATA_MASK;
  assign shifted   = {{(2*WORD_W-BYTE_W){1'b0}}, payload} << shamt;
  assign count_inc = count + VCNT_W'(1);

  always_comb begin
    step.acc      = acc | shifted[WORD_W-1:0];
    step.count    = count_inc;
    step.more     = (data_byte & VARINT_CONT_MASK) != '0;
    step.too_long = count_inc >= VCNT_W'(VARINT_BYTES);
  end
endmodule

/* bench/sorted_table_block_entry_parser_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_block_entry_parser_unit: feeds block bytes,
// predicts every header, key byte, value byte and error, and checks them in order.
// Depends on stbep_pkg, stbep_in_if, stbep_out_if and the parser RTL.
module sorted_table_block_entry_parser_unit_test;
  import stbep_pkg::*;

  localparam int KEY_MAX      = 256;
  localparam int VARINT_BYTES = 5;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int TAIL_CYCLES  = 8;       // well past the byte-to-result path through both registers
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 560;
  localparam int HOLD_CYCLES  = 300;

  // Receiver stall pattern, one bit per cycle (0 = stall).
  localparam logic [6:0] STALL_PATTERN = 7'b1101001;

  typedef enum logic [2:0] {
    PH_SHARED, PH_NEWKEY, PH_VALLEN, PH_KEY, PH_VALUE
  } parse_phase_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    byte_out;
    logic [WORD_W-1:0]    position;
    logic [OUT_LEN_W-1:0] shared_len;
    logic [OUT_LEN_W-1:0] key_len;
    logic [WORD_W-1:0]    value_len;
    logic                 zero_filled;
    logic                 entry_end;
    logic                 block_end;
    logic [ERR_W-1:0]     error_code;
  } entry_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  stbep_in_if  in_if ();
  stbep_out_if out_if ();

  sorted_table_block_entry_parser_unit #(
    .KEY_MAX      (KEY_MAX),
    .VARINT_BYTES (VARINT_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser prediction: a private copy of the entry state, advanced once per
  // accepted byte transaction.
  // ---------------------------------------------------------------------------
  parse_phase_t  pr_phase;
  logic [31:0]   pr_acc;
  int unsigned   pr_vcount;
  logic [8:0]    pr_shared;
  logic [8:0]    pr_newkey;
  logic [8:0]    pr_prev_len;
  logic [31:0]   pr_value_len;
  logic [31:0]   pr_index;
  bit            pr_skipping;

  // Results predicted but not yet seen on the result channel, oldest first.
  entry_result_t expected_results[$];

  int fail_count   = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int kind_count [4];

  // Sender burst control and receiver stall control.
  bit         gaps_on    = 1'b0;
  int         burst_left = 0;
  sink_mode_t sink_mode  = SINK_OPEN;
  int         hold_req   = 0;

  // Return every piece of parser state to its reset value; the key restarts empty.
  function automatic void clear_parser();
    pr_phase     = PH_SHARED;
    pr_acc       = '0;
    pr_vcount    = 0;
    pr_shared    = '0;
    pr_newkey    = '0;
    pr_value_len = '0;
    pr_index     = '0;
    pr_prev_len  = '0;
    pr_skipping  = 1'b0;
  endfunction

  // Build an error result. Drop the rest of the region unless this byte ends it,
  // in which case start over right away.
  function automatic entry_result_t parse_error(input logic [ERR_W-1:0] code,
                                                input logic last_byte);
    entry_result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.entry_end  = 1'b1;
    r.block_end  = last_byte;
    r.error_code = code;
    if (last_byte) clear_parser();
    else pr_skipping = 1'b1;
    return r;
  endfunction

  // Close the current entry: its full key becomes the previous key.
  function automatic void close_entry(input logic last_byte);
    pr_prev_len = pr_shared + pr_newkey;
    pr_phase    = PH_SHARED;
    pr_index    = '0;
    if (last_byte) clear_parser();
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic last_byte,
                                    output entry_result_t r);
    logic [63:0] chunk;
    logic [31:0] v;
    bit          key_last;
    bit          done;
    r = '0;
    if (pr_skipping) begin
      if (last_byte) clear_parser();
      return 1'b0;
    end
    case (pr_phase)
      PH_SHARED, PH_NEWKEY, PH_VALLEN: begin
        // Merge seven bits at a time, little end first; bits past 31 fall off.
        chunk     = 64'(b & VARINT_DATA_MASK) << (7 * pr_vcount);
        pr_acc    = pr_acc | chunk[31:0];
        pr_vcount = pr_vcount + 1;
        if ((b & VARINT_CONT_MASK) != 0) begin
          if (pr_vcount >= VARINT_BYTES) begin
            r = parse_error(ERR_VARINT_LONG, last_byte);
            return 1'b1;
          end
          if (last_byte) begin
            r = parse_error(ERR_TRUNCATED, last_byte);
            return 1'b1;
          end
          return 1'b0;
        end
        v         = pr_acc;
        pr_acc    = '0;
        pr_vcount = 0;
        if (pr_phase == PH_SHARED) begin
          if (v > 32'(KEY_MAX)) begin
            r = parse_error(ERR_KEY_LONG, last_byte);
            return 1'b1;
          end
          pr_shared = v[8:0];
          if (last_byte) begin
            r = parse_error(ERR_TRUNCATED, last_byte);
            return 1'b1;
          end
          pr_phase = PH_NEWKEY;
          return 1'b0;
        end
        if (pr_phase == PH_NEWKEY) begin
          if (v > 32'(KEY_MAX) - 32'(pr_shared)) begin
            r = parse_error(ERR_KEY_LONG, last_byte);
            return 1'b1;
          end
          pr_newkey = v[8:0];
          if (last_byte) begin
            r = parse_error(ERR_TRUNCATED, last_byte);
            return 1'b1;
          end
          pr_phase = PH_VALLEN;
          return 1'b0;
        end
        // Value length complete: emit the entry header, or a truncation error.
        pr_value_len = v;
        done = (pr_newkey == 0) && (pr_value_len == 0);
        if (last_byte && !done) begin
          r = parse_error(ERR_TRUNCATED, last_byte);
          return 1'b1;
        end
        r.kind        = KIND_HEADER;
        r.shared_len  = pr_shared;
        r.key_len     = pr_shared + pr_newkey;
        r.value_len   = pr_value_len;
        r.zero_filled = (pr_shared > pr_prev_len);
        r.entry_end   = done;
        r.block_end   = last_byte;
        pr_index      = '0;
        if (done) close_entry(last_byte);
        else pr_phase = (pr_newkey != 0) ? PH_KEY : PH_VALUE;
        return 1'b1;
      end
      PH_KEY: begin
        key_last = (pr_index + 32'd1 >= 32'(pr_newkey));
        done     = key_last && (pr_value_len == 0);
        if (last_byte && !done) begin
          r = parse_error(ERR_TRUNCATED, last_byte);
          return 1'b1;
        end
        r.kind      = KIND_KEY;
        r.byte_out  = b;
        r.position  = 32'(pr_shared) + pr_index;
        r.entry_end = done;
        r.block_end = last_byte;
        pr_index    = pr_index + 32'd1;
        if (done) begin
          close_entry(last_byte);
        end else if (key_last) begin
          pr_phase = PH_VALUE;
          pr_index = '0;
        end
        return 1'b1;
      end
      PH_VALUE: begin
        done = (pr_index + 32'd1 >= pr_value_len);
        if (last_byte && !done) begin
          r = parse_error(ERR_TRUNCATED, last_byte);
          return 1'b1;
        end
        r.kind      = KIND_VALUE;
        r.byte_out  = b;
        r.position  = pr_index;
        r.entry_end = done;
        r.block_end = last_byte;
        pr_index    = pr_index + 32'd1;
        if (done) close_entry(last_byte);
        return 1'b1;
      end
      default: begin
        clear_parser();
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Drive at the falling edge, detect acceptance at the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one byte until it is taken, then predict what it causes.
  task automatic send_byte(input logic [7:0] b, input logic last_byte);
    entry_result_t r;
    // End of a burst: hold valid low for a random gap, then start a new burst.
    if (gaps_on && burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.region_end <= last_byte;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
    if (parse_byte(b, last_byte, r)) expected_results.insert(expected_results.size(), r);
  endtask

  // Send a byte sequence, optionally marking its final byte as the region end.
  task automatic send_bytes(input logic [7:0] seq[$], input logic end_last);
    foreach (seq[i]) send_byte(seq[i], end_last && (i == seq.size() - 1));
  endtask

  // Drop valid and hold the sender until every predicted result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Append a base-128 varint; now and then pad it with redundant groups.
  function automatic void push_varint(ref logic [7:0] q[$], input logic [31:0] v);
    logic [63:0] wide;
    logic [7:0]  g;
    int          n;
    int          total;
    wide = 64'(v);
    n    = 1;
    while (n < VARINT_BYTES && (wide >> (7 * n)) != 0) n++;
    total = ($urandom_range(0, 7) == 0) ? $urandom_range(n, VARINT_BYTES) : n;
    for (int i = 0; i < total; i++) begin
      g = 8'((wide >> (7 * i)) & 64'h7F);
      if (i < total - 1) g = g | VARINT_CONT_MASK;
      q.insert(q.size(), g);
    end
  endfunction

  // Append one random entry. Mostly well formed, with an occasional key that
  // is too long or a shared prefix past the previous key.
  function automatic void push_entry(ref logic [7:0] q[$], ref int prev_len);
    int sh;
    int nk;
    int vl;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) sh = $urandom_range(KEY_MAX + 1, KEY_MAX + 40);
    else if (pick <= 2) sh = $urandom_range(prev_len,
                                            (prev_len + 4 > KEY_MAX) ? KEY_MAX : prev_len + 4);
    else if (pick == 3) sh = $urandom_range(0, KEY_MAX);
    else sh = $urandom_range(0, prev_len);
    pick = $urandom_range(0, 29);
    if (sh > KEY_MAX) nk = 1;
    else if (pick == 0) nk = KEY_MAX - sh + $urandom_range(1, 8);
    else if (pick == 1) nk = (KEY_MAX - sh > 16) ? $urandom_range(0, 16) : KEY_MAX - sh;
    else nk = $urandom_range(0, 6);
    pick = $urandom_range(0, 19);
    if (pick == 0) vl = $urandom_range(7, 40);
    else if (pick == 1) vl = 0;
    else vl = $urandom_range(0, 6);
    push_varint(q, 32'(sh));
    push_varint(q, 32'(nk));
    push_varint(q, 32'(vl));
    repeat (nk + vl) q.insert(q.size(), 8'($urandom()));
    if (sh + nk <= KEY_MAX) prev_len = sh + nk;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: receiver ready, result checking, run limit.
  // ---------------------------------------------------------------------------

  // Receiver ready. A hold request stalls it for that many cycles outright.
  initial begin
    int hold_left;
    int phase_cnt;
    hold_left    = 0;
    phase_cnt    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      phase_cnt = (phase_cnt + 1) % 7;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:   out_if.ready <= 1'b1;
          SINK_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
          default:     out_if.ready <= STALL_PATTERN[3'(phase_cnt)];
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Compare every accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    entry_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual kind %0d byte 0x%0h",
                 $time, out_if.kind, out_if.byte_out);
      end else begin
        want = expected_results.pop_front();
        kind_count[want.kind]++;
        check_field("kind",        32'(want.kind),        32'(out_if.kind));
        check_field("byte_out",    32'(want.byte_out),    32'(out_if.byte_out));
        check_field("position",    want.position,         out_if.position);
        check_field("shared_len",  32'(want.shared_len),  32'(out_if.shared_len));
        check_field("key_len",     32'(want.key_len),     32'(out_if.key_len));
        check_field("value_len",   want.value_len,        out_if.value_len);
        check_field("zero_filled", 32'(want.zero_filled), 32'(out_if.zero_filled));
        check_field("entry_end",   32'(want.entry_end),   32'(out_if.entry_end));
        check_field("block_end",   32'(want.block_end),   32'(out_if.block_end));
        check_field("error_code",  32'(want.error_code),  32'(out_if.error_code));
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header, key and value layout, the zero-filled prefix and an empty entry.
  task automatic test_entry_layout();
    sink_mode = SINK_OPEN;
    gaps_on   = 1'b0;
    // Fresh two-byte key with extreme bytes, one value byte.
    send_bytes('{8'h00, 8'h02, 8'h01, 8'hFF, 8'h00, 8'hAB}, 1'b0);
    // Shared prefix longer than the previous key: gap bytes read as zero.
    send_bytes('{8'h03, 8'h01, 8'h00, 8'h55}, 1'b0);
    // No new key bytes, two value bytes; the last one closes the region.
    send_bytes('{8'h01, 8'h00, 8'h02, 8'h12, 8'h34}, 1'b1);
    // Header-only entry on the region end.
    send_bytes('{8'h00, 8'h00, 8'h00}, 1'b1);
    wait_drained();
  endtask

  // Five-byte varints, bits past 31, and a varint that runs too long.
  task automatic test_varint_limits();
    sink_mode = SINK_RANDOM;
    gaps_on   = 1'b1;
    // All-ones value length, then truncate on its first value byte.
    send_bytes('{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC3}, 1'b1);
    // Continuation on the fifth byte; the rest of the region is swallowed.
    send_bytes('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h11, 8'h22}, 1'b1);
    // Same error on the region end byte itself: start over at once.
    send_bytes('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80}, 1'b1);
    // Padded five-byte shared length of one on an empty previous key.
    send_bytes('{8'h81, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00}, 1'b1);
    wait_drained();
  endtask

  // Key length limits on the shared and the new key varints.
  task automatic test_key_limits();
    sink_mode = SINK_PATTERN;
    gaps_on   = 1'b0;
    // Shared length one past the limit.
    send_bytes('{8'h81, 8'h02, 8'h00}, 1'b1);
    // Shared at the limit, then one new byte too many on the region end.
    send_bytes('{8'h80, 8'h02, 8'h01}, 1'b1);
    // Key exactly at the limit, all of it zero filled.
    send_bytes('{8'h80, 8'h02, 8'h00, 8'h00}, 1'b1);
    wait_drained();
  endtask

  // Region end inside each part of an entry.
  task automatic test_truncation();
    sink_mode = SINK_RANDOM;
    gaps_on   = 1'b1;
    send_bytes('{8'h80}, 1'b1);
    send_bytes('{8'h05}, 1'b1);
    send_bytes('{8'h00, 8'h04}, 1'b1);
    send_bytes('{8'h00, 8'h01, 8'h00}, 1'b1);
    send_bytes('{8'h00, 8'h02, 8'h00, 8'hAA}, 1'b1);
    send_bytes('{8'h00, 8'h00, 8'h03, 8'h01}, 1'b1);
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering, so the block fills
  // and stalls its input; then release and let it drain.
  task automatic test_stalled_output();
    logic [7:0] seq[$];
    sink_mode = SINK_OPEN;
    gaps_on   = 1'b0;
    hold_req  = HOLD_CYCLES;
    seq = '{8'h00, 8'h04, 8'h28};
    repeat (44) seq.insert(seq.size(), 8'($urandom()));
    send_bytes(seq, 1'b1);
    wait_drained();
  endtask

  // Random regions: mostly well-formed entry runs, some cut short, some noise.
  task automatic test_random_blocks();
    logic [7:0] seq[$];
    int         prev_len;
    int         cut;
    int         pick;
    int         start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      seq       = {};
      prev_len  = 0;
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      gaps_on   = ($urandom_range(0, 3) != 0);
      pick      = $urandom_range(0, 9);
      if (pick == 0) begin
        // Noise with scattered region ends; always close the region at the end.
        repeat ($urandom_range(1, 12)) seq.insert(seq.size(), 8'($urandom()));
        foreach (seq[i])
          send_byte(seq[i], (i == seq.size() - 1) || ($urandom_range(0, 7) == 0));
      end else begin
        repeat ($urandom_range(1, 5)) push_entry(seq, prev_len);
        cut = (pick == 1) ? $urandom_range(0, seq.size() - 1) : seq.size() - 1;
        for (int i = 0; i <= cut; i++) send_byte(seq[i], i == cut);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.region_end = 1'b0;
    foreach (kind_count[k]) kind_count[k] = 0;
    clear_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_entry_layout();
    test_varint_limits();
    test_key_limits();
    test_truncation();
    test_stalled_output();
    test_random_blocks();

    // Wait out the pipeline so a stray extra result still gets caught.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d block bytes: %0d headers, %0d key, %0d value, %0d errors.",
             bytes_sent, kind_count[KIND_HEADER], kind_count[KIND_KEY],
             kind_count[KIND_VALUE], kind_count[KIND_ERROR]);
    $display("Compared %0d result transactions, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/stbep_pkg.sv
rtl/core/stbep_in_if.sv
rtl/core/stbep_out_if.sv
rtl/core/stbep_varint.sv
rtl/core/sorted_table_block_entry_parser_unit.sv
bench/sorted_table_block_entry_parser_unit_test.sv
